[hw/rtl/scc_pkg.sv]
// Shared types and constants for the SCC pair counter.
// No dependencies; imported by scc_pair_acc and scc_pair_counter_top.
package scc_pkg;

  localparam int SIZE_W = 17;   // component size, up to 131071 nodes
  localparam int PAIR_W = 19;
  localparam int COMP_W = 11;

  localparam logic REQ_EDGE   = 1'b0;
  localparam logic REQ_FINISH = 1'b1;

  typedef struct packed {
    logic              clr;
    logic              add;
    logic [SIZE_W-1:0] size;
  } acc_ctl_t;

  typedef struct packed {
    logic              busy;
    logic [PAIR_W-1:0] pair_sum;
    logic [COMP_W-1:0] comps;
  } acc_stat_t;

endpackage

[hw/rtl/scc_pair_counter_top.sv]
// Strongly connected component pair counter: graph stores and walk sequencer.
// Depends on scc_pkg, scc_ram and scc_pair_acc.
//
// Usage:
//   in_*  : one word per request. in_tuser = req_type (0 edge, 1 finish).
//           An accepted edge word does a head read, then a link write.
//   out_* : one word per finish, carrying the pair total, component count
//           and the dropped-edge flag.
//   cfg_* : writes node_count; always ready. Write only while idle.
// Walk: a finish runs two depth-first passes over the graph stores, a
//   forward pass and then a reverse pass, with a sweep of the visited
//   marks between them; the walk is bounded by the single read port of
//   each memory. After the result is loaded, another sweep clears the
//   heads and marks before the next word.
// Reset: a clearing sweep of the heads and marks runs first; in_tready stays low.
// Stall: the result sits in an output register; edge words are still taken
//   while it waits, a later finish waits before loading its result.
module scc_pair_counter_top import scc_pkg::*; #(
  parameter int MAX_NODES = 1024,
  parameter int MAX_EDGES = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,    // src_node[9:0], dst_node[19:10], zero pad
  input  logic [0:0]  in_tuser,    // req_type
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,   // pair_total[18:0], component_total[29:19],
                                   // edges_dropped[30], zero pad
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [10:0] cfg_data
);

  localparam int NW  = $clog2(MAX_NODES);
  localparam int NCW = NW + 1;
  localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int EPW = $clog2(MAX_EDGES + 1);
  localparam logic [EPW-1:0] EMPTY = EPW'(MAX_EDGES);

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_LINK = 4'd1;
  localparam logic [3:0] ST_CLR  = 4'd2;
  localparam logic [3:0] ST_SCAN = 4'd3;
  localparam logic [3:0] ST_ORD  = 4'd4;
  localparam logic [3:0] ST_ROOT = 4'd5;
  localparam logic [3:0] ST_STEP = 4'd6;
  localparam logic [3:0] ST_EDAT = 4'd7;
  localparam logic [3:0] ST_VCHK = 4'd8;
  localparam logic [3:0] ST_POP  = 4'd9;
  localparam logic [3:0] ST_OUT  = 4'd10;

  logic [3:0]     state_r, state_nxt;
  logic [10:0]    node_count_r, node_count_nxt;
  logic           pass_r, pass_nxt;
  logic           clr_all_r, clr_all_nxt;
  logic [EPW-1:0] fill_r, fill_nxt;
  logic           drop_r, drop_nxt;
  logic [NCW-1:0] idx_r, idx_nxt;
  logic [NCW-1:0] ofill_r, ofill_nxt;
  logic [NW-1:0]  clr_idx_r, clr_idx_nxt;
  logic [NCW-1:0] depth_r, depth_nxt;
  logic           out_valid_r, out_valid_nxt;
  logic [NW-1:0]  a_r, a_nxt, b_r, b_nxt;
  logic [NW-1:0]  root_r, root_nxt;
  logic [NW-1:0]  top_node_r, top_node_nxt;
  logic [EPW-1:0] top_edge_r, top_edge_nxt;
  logic [NCW-1:0] done_r, done_nxt;
  logic [NW-1:0]  t_r, t_nxt;
  logic [31:0]    out_data_r, out_data_nxt;

  // memory ports
  logic              hf_we, hr_we, ef_we, er_we, vis_we, ord_we, stk_we;
  logic [NW-1:0]     hf_waddr, hr_waddr, vis_waddr, ord_waddr, stk_waddr;
  logic [NW-1:0]     hf_raddr, hr_raddr, vis_raddr, ord_raddr, stk_raddr;
  logic [EAW-1:0]    ef_waddr, er_waddr, e_raddr;
  logic [EPW-1:0]    hf_wdata, hr_wdata, hf_rdata, hr_rdata;
  logic [EPW+NW-1:0] ef_wdata, er_wdata, ef_rdata, er_rdata;
  logic              vis_wdata, vis_rdata;
  logic [NW-1:0]     ord_wdata, ord_rdata;
  logic [NW+EPW-1:0] stk_wdata, stk_rdata;

  acc_ctl_t  acc_ctl;
  acc_stat_t acc_stat;

  logic [31:0]       n32, src32, dst32;
  logic              edge_bad;
  logic [EPW-1:0]    head_rd;
  logic [EPW+NW-1:0] edge_rd;
  logic [NW-1:0]     tgt;
  logic [NCW-1:0]    idx_dec, depth_m1, depth_m2, done_inc;

  assign n32   = (32'(node_count_r) > 32'(MAX_NODES)) ? 32'(MAX_NODES)
                                                      : 32'(node_count_r);
  assign src32 = 32'(in_tdata[9:0]);
  assign dst32 = 32'(in_tdata[19:10]);
  assign edge_bad = (src32 >= n32) || (dst32 >= n32) || (fill_r == EMPTY);

  assign head_rd  = pass_r ? hr_rdata : hf_rdata;
  assign edge_rd  = pass_r ? er_rdata : ef_rdata;
  assign tgt      = edge_rd[NW-1:0];
  assign idx_dec  = idx_r - NCW'(1);
  assign depth_m1 = depth_r - NCW'(1);
  assign depth_m2 = depth_r - NCW'(2);
  assign done_inc = done_r + NCW'(1);

  assign in_tready  = (state_r == ST_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_comb begin
    state_nxt      = state_r;
    node_count_nxt = node_count_r;
    pass_nxt       = pass_r;
    clr_all_nxt    = clr_all_r;
    fill_nxt       = fill_r;
    drop_nxt       = drop_r;
    idx_nxt        = idx_r;
    ofill_nxt      = ofill_r;
    clr_idx_nxt    = clr_idx_r;
    depth_nxt      = depth_r;
    out_valid_nxt  = out_valid_r;
    a_nxt          = a_r;
    b_nxt          = b_r;
    root_nxt       = root_r;
    top_node_nxt   = top_node_r;
    top_edge_nxt   = top_edge_r;
    done_nxt       = done_r;
    t_nxt          = t_r;
    out_data_nxt   = out_data_r;

    hf_we = 1'b0; hr_we = 1'b0; ef_we = 1'b0; er_we = 1'b0;
    vis_we = 1'b0; ord_we = 1'b0; stk_we = 1'b0;
    hf_waddr = '0; hr_waddr = '0; vis_waddr = '0; ord_waddr = '0; stk_waddr = '0;
    hf_raddr = '0; hr_raddr = '0; vis_raddr = '0; ord_raddr = '0; stk_raddr = '0;
    ef_waddr = '0; er_waddr = '0; e_raddr = '0;
    hf_wdata = '0; hr_wdata = '0; ef_wdata = '0; er_wdata = '0;
    vis_wdata = 1'b0; ord_wdata = '0; stk_wdata = '0;
    acc_ctl = '0;

    if (cfg_valid) begin
      node_count_nxt = cfg_data;
    end
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          if (in_tuser[0] == REQ_FINISH) begin
            idx_nxt     = '0;
            ofill_nxt   = '0;
            pass_nxt    = 1'b0;
            acc_ctl.clr = 1'b1;
            state_nxt   = ST_SCAN;
          end else if (edge_bad) begin
            drop_nxt = 1'b1;
          end else begin
            a_nxt     = src32[NW-1:0];
            b_nxt     = dst32[NW-1:0];
            hf_raddr  = src32[NW-1:0];
            hr_raddr  = dst32[NW-1:0];
            state_nxt = ST_LINK;
          end
        end
      end
      ST_LINK: begin
        // push the new edge on the front of both adjacency lists
        ef_we    = 1'b1;
        ef_waddr = fill_r[EAW-1:0];
        ef_wdata = {hf_rdata, b_r};
        er_we    = 1'b1;
        er_waddr = fill_r[EAW-1:0];
        er_wdata = {hr_rdata, a_r};
        hf_we    = 1'b1;
        hf_waddr = a_r;
        hf_wdata = fill_r;
        hr_we    = 1'b1;
        hr_waddr = b_r;
        hr_wdata = fill_r;
        fill_nxt = fill_r + EPW'(1);
        state_nxt = ST_IDLE;
      end
      ST_CLR: begin
        hf_we     = clr_all_r;
        hr_we     = clr_all_r;
        hf_waddr  = clr_idx_r;
        hr_waddr  = clr_idx_r;
        hf_wdata  = EMPTY;
        hr_wdata  = EMPTY;
        vis_we    = 1'b1;
        vis_waddr = clr_idx_r;
        vis_wdata = 1'b0;
        if (clr_idx_r == NW'(MAX_NODES - 1)) begin
          clr_idx_nxt = '0;
          if (clr_all_r) begin
            state_nxt = ST_IDLE;
          end else begin
            pass_nxt  = 1'b1;
            idx_nxt   = ofill_r;
            state_nxt = ST_SCAN;
          end
        end else begin
          clr_idx_nxt = clr_idx_r + NW'(1);
        end
      end
      ST_SCAN: begin
        if (!pass_r) begin
          if (32'(idx_r) < n32) begin
            vis_raddr = idx_r[NW-1:0];
            hf_raddr  = idx_r[NW-1:0];
            hr_raddr  = idx_r[NW-1:0];
            root_nxt  = idx_r[NW-1:0];
            idx_nxt   = idx_r + NCW'(1);
            state_nxt = ST_ROOT;
          end else begin
            clr_all_nxt = 1'b0;
            clr_idx_nxt = '0;
            state_nxt   = ST_CLR;
          end
        end else begin
          // reverse finish order
          if (idx_r != '0) begin
            ord_raddr = idx_dec[NW-1:0];
            idx_nxt   = idx_dec;
            state_nxt = ST_ORD;
          end else begin
            state_nxt = ST_OUT;
          end
        end
      end
      ST_ORD: begin
        if (32'(ord_rdata) >= n32) begin
          state_nxt = ST_SCAN;
        end else begin
          vis_raddr = ord_rdata;
          hf_raddr  = ord_rdata;
          hr_raddr  = ord_rdata;
          root_nxt  = ord_rdata;
          state_nxt = ST_ROOT;
        end
      end
      ST_ROOT: begin
        if (vis_rdata) begin
          state_nxt = ST_SCAN;
        end else begin
          vis_we       = 1'b1;
          vis_waddr    = root_r;
          vis_wdata    = 1'b1;
          top_node_nxt = root_r;
          top_edge_nxt = head_rd;
          depth_nxt    = NCW'(1);
          done_nxt     = '0;
          state_nxt    = ST_STEP;
        end
      end
      ST_STEP: begin
        if (top_edge_r >= EMPTY) begin
          // node finished
          done_nxt  = done_inc;
          depth_nxt = depth_m1;
          if (!pass_r && (32'(ofill_r) < 32'(MAX_NODES))) begin
            ord_we    = 1'b1;
            ord_waddr = ofill_r[NW-1:0];
            ord_wdata = top_node_r;
            ofill_nxt = ofill_r + NCW'(1);
          end
          if (depth_r == NCW'(1)) begin
            acc_ctl.add  = pass_r;
            acc_ctl.size = SIZE_W'(done_inc);
            state_nxt    = ST_SCAN;
          end else begin
            stk_raddr = depth_m2[NW-1:0];
            state_nxt = ST_POP;
          end
        end else begin
          e_raddr   = top_edge_r[EAW-1:0];
          state_nxt = ST_EDAT;
        end
      end
      ST_POP: begin
        top_node_nxt = stk_rdata[EPW +: NW];
        top_edge_nxt = stk_rdata[EPW-1:0];
        state_nxt    = ST_STEP;
      end
      ST_EDAT: begin
        top_edge_nxt = edge_rd[NW +: EPW];
        if (32'(tgt) < n32) begin
          t_nxt     = tgt;
          vis_raddr = tgt;
          hf_raddr  = tgt;
          hr_raddr  = tgt;
          state_nxt = ST_VCHK;
        end else begin
          state_nxt = ST_STEP;
        end
      end
      ST_VCHK: begin
        if (!vis_rdata && (32'(depth_r) < 32'(MAX_NODES))) begin
          stk_we       = 1'b1;
          stk_waddr    = depth_m1[NW-1:0];
          stk_wdata    = {top_node_r, top_edge_r};
          vis_we       = 1'b1;
          vis_waddr    = t_r;
          vis_wdata    = 1'b1;
          top_node_nxt = t_r;
          top_edge_nxt = head_rd;
          depth_nxt    = depth_r + NCW'(1);
        end
        state_nxt = ST_STEP;
      end
      ST_OUT: begin
        if (!out_valid_r && !acc_stat.busy) begin
          out_data_nxt  = {1'b0, drop_r, acc_stat.comps, acc_stat.pair_sum};
          out_valid_nxt = 1'b1;
          drop_nxt      = 1'b0;
          fill_nxt      = '0;
          clr_all_nxt   = 1'b1;
          clr_idx_nxt   = '0;
          state_nxt     = ST_CLR;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLR;
      node_count_r <= 11'd1024;
      pass_r       <= 1'b0;
      clr_all_r    <= 1'b1;
      fill_r       <= '0;
      drop_r       <= 1'b0;
      idx_r        <= '0;
      ofill_r      <= '0;
      clr_idx_r    <= '0;
      depth_r      <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      node_count_r <= node_count_nxt;
      pass_r       <= pass_nxt;
      clr_all_r    <= clr_all_nxt;
      fill_r       <= fill_nxt;
      drop_r       <= drop_nxt;
      idx_r        <= idx_nxt;
      ofill_r      <= ofill_nxt;
      clr_idx_r    <= clr_idx_nxt;
      depth_r      <= depth_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    a_r        <= a_nxt;
    b_r        <= b_nxt;
    root_r     <= root_nxt;
    top_node_r <= top_node_nxt;
    top_edge_r <= top_edge_nxt;
    done_r     <= done_nxt;
    t_r        <= t_nxt;
    out_data_r <= out_data_nxt;
  end

  scc_ram #(.WIDTH(EPW), .DEPTH(MAX_NODES)) u_fwd_head (
    .clk(clk), .we(hf_we), .waddr(hf_waddr), .wdata(hf_wdata),
    .raddr(hf_raddr), .rdata(hf_rdata)
  );
  scc_ram #(.WIDTH(EPW), .DEPTH(MAX_NODES)) u_rev_head (
    .clk(clk), .we(hr_we), .waddr(hr_waddr), .wdata(hr_wdata),
    .raddr(hr_raddr), .rdata(hr_rdata)
  );
  scc_ram #(.WIDTH(EPW + NW), .DEPTH(MAX_EDGES)) u_fwd_edge (
    .clk(clk), .we(ef_we), .waddr(ef_waddr), .wdata(ef_wdata),
    .raddr(e_raddr), .rdata(ef_rdata)
  );
  scc_ram #(.WIDTH(EPW + NW), .DEPTH(MAX_EDGES)) u_rev_edge (
    .clk(clk), .we(er_we), .waddr(er_waddr), .wdata(er_wdata),
    .raddr(e_raddr), .rdata(er_rdata)
  );
  scc_ram #(.WIDTH(1), .DEPTH(MAX_NODES)) u_visited (
    .clk(clk), .we(vis_we), .waddr(vis_waddr), .wdata(vis_wdata),
    .raddr(vis_raddr), .rdata(vis_rdata)
  );
  scc_ram #(.WIDTH(NW), .DEPTH(MAX_NODES)) u_order (
    .clk(clk), .we(ord_we), .waddr(ord_waddr), .wdata(ord_wdata),
    .raddr(ord_raddr), .rdata(ord_rdata)
  );
  scc_ram #(.WIDTH(NW + EPW), .DEPTH(MAX_NODES)) u_stack (
    .clk(clk), .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
    .raddr(stk_raddr), .rdata(stk_rdata)
  );

  scc_pair_acc u_acc (
    .clk(clk), .rst_n(rst_n), .ctl(acc_ctl), .stat(acc_stat)
  );

`ifndef SYNTHESIS
  a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(depth_r) <= 32'(MAX_NODES))
    else $error("walk depth above node capacity");
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= EMPTY)
    else $error("edge fill above capacity");
  a_order_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(ofill_r) <= 32'(MAX_NODES))
    else $error("finish order overflow");
  a_finish_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && (in_tuser[0] == REQ_FINISH)) |=> !in_tready)
    else $error("input taken during walk");
`endif

endmodule

[hw/rtl/scc_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module scc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hw/rtl/scc_pair_acc.sv]
// Component size accumulator: adds size*(size-1)/2 and counts components.
// Depends on scc_pkg.
module scc_pair_acc import scc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  acc_ctl_t  ctl,
  output acc_stat_t stat
);

  localparam int PW = 2 * SIZE_W;

  logic [PW-1:0]     prod_r, prod_nxt;
  logic              add_r, add_nxt;
  logic [PAIR_W-1:0] sum_r, sum_nxt;
  logic [COMP_W-1:0] comps_r, comps_nxt;
  logic [PW-1:0]     sz_ext, szm1_ext;

  always_comb begin
    sz_ext    = PW'(ctl.size);
    szm1_ext  = PW'(ctl.size - SIZE_W'(1));
    prod_nxt  = sz_ext * szm1_ext;
    add_nxt   = ctl.add & ~ctl.clr;
    sum_nxt   = sum_r;
    comps_nxt = comps_r;
    if (ctl.clr) begin
      sum_nxt   = '0;
      comps_nxt = '0;
    end else if (add_r) begin
      // product is even, so the halving is exact
      sum_nxt   = sum_r + prod_r[PAIR_W:1];
      comps_nxt = comps_r + COMP_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    if (!rst_n) begin
      add_r   <= 1'b0;
      sum_r   <= '0;
      comps_r <= '0;
    end else begin
      add_r   <= add_nxt;
      sum_r   <= sum_nxt;
      comps_r <= comps_nxt;
    end
  end

  assign stat.busy     = add_r;
  assign stat.pair_sum = sum_r;
  assign stat.comps    = comps_r;

endmodule

[tb/scc_pair_counter_top_test.sv]
// Testbench for scc_pair_counter_top: random and directed graphs, SCC pair totals checked
// against an in-bench Kosaraju predictor. Depends on scc_pkg and the scc_pair_counter_top RTL.
`timescale 1ns / 1ps

module scc_pair_counter_top_test import scc_pkg::*; ();

  localparam int NODES = 1024;
  localparam int EDGES = 4096;
  localparam longint CYCLE_LIMIT = 64'd40000000;

  typedef struct packed {
    logic       kind;
    logic [9:0] src;
    logic [9:0] dst;
  } req_t;

  typedef struct packed {
    logic [18:0] pairs;
    logic [10:0] comps;
    logic        dropped;
  } scc_result_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata = '0;
  logic [0:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [10:0] cfg_data;

  scc_pair_counter_top uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  // predictor state
  int unsigned node_limit;
  int unsigned g_fwd_head[NODES];
  int unsigned g_fwd_next[EDGES];
  int unsigned g_fwd_tgt[EDGES];
  int unsigned g_rev_head[NODES];
  int unsigned g_rev_next[EDGES];
  int unsigned g_rev_tgt[EDGES];
  int unsigned g_edge_cnt;
  bit          g_dropped;
  bit          seen[NODES];
  int unsigned post_order[NODES];
  int unsigned post_cnt;
  int unsigned stk_node[NODES];
  int unsigned stk_edge[NODES];

  req_t        pending_reqs[$];
  scc_result_t expected_totals[$];
  int          send_idle_pct;
  int          recv_idle_pct;
  bit          hold_sender;
  int          error_count = 0;
  int          results_seen = 0;
  int          finishes_sent = 0;
  longint      cycles = 0;

  function automatic void clear_graph();
    for (int i = 0; i < NODES; i++) begin
      g_fwd_head[i] = EDGES;
      g_rev_head[i] = EDGES;
    end
    g_edge_cnt = 0;
    g_dropped = 0;
  endfunction

  function automatic int unsigned dfs_from(int unsigned root, bit rev, int unsigned n);
    int unsigned depth;
    int unsigned done;
    int unsigned e;
    int unsigned t;
    depth = 1;
    done = 0;
    seen[root] = 1;
    stk_node[0] = root;
    stk_edge[0] = rev ? g_rev_head[root] : g_fwd_head[root];
    while (depth > 0) begin
      e = stk_edge[depth-1];
      if (e >= EDGES || e >= g_edge_cnt) begin
        depth--;
        done++;
        if (!rev && post_cnt < NODES) begin
          post_order[post_cnt] = stk_node[depth];
          post_cnt++;
        end
      end else begin
        t = rev ? g_rev_tgt[e] : g_fwd_tgt[e];
        stk_edge[depth-1] = rev ? g_rev_next[e] : g_fwd_next[e];
        if (t < n && !seen[t] && depth < NODES) begin
          seen[t] = 1;
          stk_node[depth] = t;
          stk_edge[depth] = rev ? g_rev_head[t] : g_fwd_head[t];
          depth++;
        end
      end
    end
    return done;
  endfunction

  // Applies one request; queues the expected word on a finish.
  function automatic void predict_scc(req_t r);
    int unsigned n;
    int unsigned sz;
    longint unsigned total;
    int unsigned ncomp;
    scc_result_t res;
    n = node_limit > NODES ? NODES : node_limit;
    if (r.kind == REQ_EDGE) begin
      if (r.src >= n || r.dst >= n || g_edge_cnt >= EDGES) begin
        g_dropped = 1;
      end else begin
        g_fwd_tgt[g_edge_cnt] = r.dst;
        g_fwd_next[g_edge_cnt] = g_fwd_head[r.src];
        g_fwd_head[r.src] = g_edge_cnt;
        g_rev_tgt[g_edge_cnt] = r.src;
        g_rev_next[g_edge_cnt] = g_rev_head[r.dst];
        g_rev_head[r.dst] = g_edge_cnt;
        g_edge_cnt++;
      end
      return;
    end
    foreach (seen[i]) seen[i] = 0;
    post_cnt = 0;
    for (int unsigned i = 0; i < n; i++)
      if (!seen[i]) void'(dfs_from(i, 0, n));
    foreach (seen[i]) seen[i] = 0;
    total = 0;
    ncomp = 0;
    for (int unsigned i = post_cnt; i > 0; i--) begin
      if (post_order[i-1] < n && !seen[post_order[i-1]]) begin
        sz = dfs_from(post_order[i-1], 1, n);
        total += longint'(sz) * (sz - 1) / 2;
        ncomp++;
      end
    end
    res.pairs = total[18:0];
    res.comps = ncomp[10:0];
    res.dropped = g_dropped;
    expected_totals.insert(expected_totals.size(), res);
    clear_graph();
  endfunction

  function automatic req_t edge_req(int unsigned a, int unsigned b);
    req_t r;
    r.kind = REQ_EDGE;
    r.src = a[9:0];
    r.dst = b[9:0];
    return r;
  endfunction

  function automatic req_t finish_req();
    req_t r;
    r.kind = REQ_FINISH;
    r.src = 10'($urandom);
    r.dst = 10'($urandom);
    return r;
  endfunction

  function automatic void queue_req(req_t r);
    pending_reqs.insert(pending_reqs.size(), r);
  endfunction

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 0;
    end else if (!in_tvalid || in_tready) begin
      if (pending_reqs.size() > 0 && !hold_sender &&
          $urandom_range(99) >= send_idle_pct) begin
        req_t r;
        r = pending_reqs.pop_front();
        predict_scc(r);
        if (r.kind == REQ_FINISH) finishes_sent++;
        in_tvalid <= 1;
        in_tdata <= {4'b0, r.dst, r.src};
        in_tuser <= r.kind;
      end else begin
        in_tvalid <= 0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst_n) out_tready <= ($urandom_range(99) >= recv_idle_pct);
    if (rst_n && out_tvalid && out_tready) begin
      scc_result_t got;
      scc_result_t want;
      got.pairs = out_tdata[18:0];
      got.comps = out_tdata[29:19];
      got.dropped = out_tdata[30];
      results_seen++;
      if (expected_totals.size() == 0) begin
        $error("unexpected result word %h", out_tdata);
        error_count++;
      end else begin
        want = expected_totals.pop_front();
        if (got.pairs !== want.pairs) begin
          $error("pair_total expected %0d got %0d", want.pairs, got.pairs);
          error_count++;
        end
        if (got.comps !== want.comps) begin
          $error("component_total expected %0d got %0d", want.comps, got.comps);
          error_count++;
        end
        if (got.dropped !== want.dropped) begin
          $error("edges_dropped expected %0d got %0d", want.dropped, got.dropped);
          error_count++;
        end
      end
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("scc_pair_counter_top verification failed");
      $finish;
    end
  end

  task automatic drain();
    while (pending_reqs.size() > 0 || in_tvalid) @(posedge clk);
    while (expected_totals.size() > 0) @(posedge clk);
    repeat (5000) @(posedge clk);
  endtask

  task automatic write_nodes(int unsigned v);
    node_limit = v & 11'h7ff;
    @(posedge clk);
    cfg_valid <= 1;
    cfg_data <= v[10:0];
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 0;
  endtask

  // One random graph: mostly in-range edges, some cycles, a little noise.
  task automatic queue_graph(int unsigned n, int unsigned nedges);
    int unsigned span;
    span = (n == 0) ? 1 : n;
    for (int unsigned i = 0; i < nedges; i++) begin
      if ($urandom_range(19) == 0)
        queue_req(edge_req($urandom_range(1023), $urandom_range(1023)));
      else if ($urandom_range(3) == 0 && i + 1 < nedges) begin
        int unsigned a;
        int unsigned b;
        a = $urandom_range(span - 1);
        b = $urandom_range(span - 1);
        queue_req(edge_req(a, b));
        queue_req(edge_req(b, a));
        i++;
      end else
        queue_req(edge_req($urandom_range(span - 1), $urandom_range(span - 1)));
    end
    queue_req(finish_req());
  endtask

  task automatic random_phase(int unsigned items);
    int unsigned queued;
    int unsigned n;
    int unsigned ne;
    queued = 0;
    while (queued < items) begin
      n = node_limit > NODES ? NODES : node_limit;
      ne = $urandom_range(3) == 0 ? $urandom_range(60) : $urandom_range(12);
      queue_graph(n, ne);
      queued += ne + 1;
    end
    drain();
  endtask

  initial begin
    int unsigned sizes[6];
    int fin_mark;
    rst_n = 0;
    cfg_valid = 0;
    cfg_data = 0;
    hold_sender = 0;
    send_idle_pct = 21;
    recv_idle_pct = 84;
    node_limit = 1024;
    clear_graph();
    repeat (10) @(posedge clk);
    rst_n <= 1;

    // directed: full node range, extremes, self loop, parallel edges
    queue_req(edge_req(0, 1023));
    queue_req(edge_req(1023, 0));
    queue_req(edge_req(5, 5));
    queue_req(edge_req(1, 2));
    queue_req(edge_req(1, 2));
    queue_req(edge_req(2, 1));
    queue_req(edge_req(682, 341));
    queue_req(finish_req());
    queue_req(finish_req());
    drain();

    // small node count: bad edges dropped
    write_nodes(4);
    queue_req(edge_req(0, 1));
    queue_req(edge_req(1, 2));
    queue_req(edge_req(2, 0));
    queue_req(edge_req(3, 4));
    queue_req(finish_req());
    drain();

    // node count lowered after loading: wait for idle first, then finish
    write_nodes(8);
    queue_req(edge_req(6, 7));
    queue_req(edge_req(7, 6));
    queue_req(edge_req(0, 1));
    queue_req(edge_req(1, 0));
    drain();
    write_nodes(3);
    queue_req(finish_req());
    drain();

    // zero nodes and above-capacity count
    write_nodes(0);
    queue_req(edge_req(0, 0));
    queue_req(finish_req());
    drain();
    write_nodes(2047);
    queue_req(edge_req(1023, 1023));
    queue_req(finish_req());
    drain();

    // random phases over several node counts
    sizes = '{16, 2, 1024, 37, 1, 300};
    foreach (sizes[k]) begin
      if (k == 2) begin send_idle_pct = 84; recv_idle_pct = 21; end
      if (k == 4) begin send_idle_pct = 0; recv_idle_pct = 0; end
      write_nodes(sizes[k]);
      random_phase(300);
      if (k == 1) begin
        // sender holds off mid-stream until all results are back
        fin_mark = finishes_sent;
        queue_graph(2, 5);
        queue_graph(2, 5);
        while (finishes_sent == fin_mark) @(posedge clk);
        hold_sender = 1;
        while (expected_totals.size() > 0) @(posedge clk);
        hold_sender = 0;
        drain();
      end
    end

    $display("covered %0d finish words over node counts 0..2047 incl. dropped edges",
             finishes_sent);
    $display("%0d result words checked", results_seen);
    if (error_count == 0 && expected_totals.size() == 0)
      $display("scc_pair_counter_top verification clean");
    else
      $display("scc_pair_counter_top verification failed");
    $finish;
  end

endmodule
